### design/bee_pkg.sv
// shared types, constants and character tables for the byte escape encoder
package bee_pkg;

    // configuration and counting limits
    localparam logic [15:0] BUF_SIZE_RESET = 16'd512;
    localparam logic [19:0] NEED_MAX       = 20'hFFFFF;
    localparam int          SEQ_MAX        = 4;

    // ascii codes used by the escaper
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7E;

    // escape lengths
    localparam logic [2:0] LEN_PLAIN = 3'd1;
    localparam logic [2:0] LEN_CTL   = 3'd2;
    localparam logic [2:0] LEN_HEX   = 3'd4;

    // index of a control letter within "tnvfr"
    typedef enum logic [2:0] {
        CTL_T = 3'd0,
        CTL_N = 3'd1,
        CTL_V = 3'd2,
        CTL_F = 3'd3,
        CTL_R = 3'd4
    } ctl_idx_t;

    // one raw byte request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } raw_item_t;

    // one output character request
    typedef struct packed {
        logic [7:0]  out_char;
        logic        is_terminator;
        logic [19:0] needed_total;
        logic        run_last;
    } text_item_t;

    // configuration write request
    typedef struct packed {
        logic [15:0] buffer_size;
    } cfg_item_t;

    // all results caused by one byte, ready for serialising
    typedef struct packed {
        logic [SEQ_MAX-1:0][7:0] chars;
        logic [2:0]              nchar;
        logic                    term;
        logic [19:0]             need;
    } burst_t;

    // letter after the backslash for bytes 9 to 13
    function automatic logic [7:0] ctl_letter(input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h74;
        unique case (idx)
            CTL_T:   ch = 8'h74;
            CTL_N:   ch = 8'h6E;
            CTL_V:   ch = 8'h76;
            CTL_F:   ch = 8'h66;
            CTL_R:   ch = 8'h72;
            default: ch = 8'h74;
        endcase
        return ch;
    endfunction

    // upper-case hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
            ch = 8'h30 + {4'd0, nib};
        else
            ch = 8'h37 + {4'd0, nib};
        return ch;
    endfunction

endpackage

### design/stream_if.sv
// valid/ready channel carrying one payload of a chosen type
interface stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/byte_escape_encoder.sv
// byte escape encoder: raw bytes in, one character per request out
//
// channels: raw_bytes takes one byte per request (in_byte, last_byte);
// text_chars gives one character per request, and after the last byte of
// a string a terminator request with out_char zero and needed_total, the
// buffer size the whole escaped string needs including the terminator;
// cfg writes buffer_size, which is sampled when the next string starts.
// a byte gives one, two or four characters (plain, control, hex escape),
// each only if it still fits with a place kept for the terminator.
// a byte that is taken is held in the staging register and then moves into
// the output register, from which its first result is offered.
// throughput: the single output character register gives one result per
// cycle while text_chars is ready, and a byte's results leave one by one:
// one for printable bytes, up to five for a final hex escape. a byte that
// causes no result never enters the staging register. one burst waits in
// the staging register while the previous one drains, so raw_bytes stays
// ready while text_chars stalls until that staging register is full.
// reset empties both registers, ends any open string and sets buffer_size
// to 512. cfg is always ready.
module byte_escape_encoder
    import bee_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    stream_if.sink   raw_bytes,
    stream_if.source text_chars,
    stream_if.sink   cfg
);

    logic [15:0] buffer_size_reg;
    logic        active_reg, active_next;
    logic [15:0] space_reg, space_next;
    logic [19:0] need_reg, need_next;

    logic        a_valid_reg, a_valid_next;
    burst_t      a_burst_reg;
    logic        b_valid_reg, b_valid_next;
    burst_t      b_burst_reg;
    logic [2:0]  b_idx_reg, b_idx_next;

    logic [7:0]  b;
    logic        last;
    logic        in_fire;
    logic        out_fire;
    logic [2:0]  len;
    logic [SEQ_MAX-1:0][7:0] seq;
    logic [15:0] space_eff;
    logic [19:0] need_base;
    logic [20:0] need_sum;
    logic [19:0] need_new;
    logic        fits;
    logic        load_a;
    burst_t      new_burst;
    logic [2:0]  b_total;
    logic        b_final;
    logic        b_free;
    logic        a_move;
    logic        is_char;

    assign b    = raw_bytes.data.in_byte;
    assign last = raw_bytes.data.last_byte;

    // configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buffer_size_reg <= BUF_SIZE_RESET;
        else if (cfg.valid)
            buffer_size_reg <= cfg.data.buffer_size;
    end

    // escape sequence for the incoming byte
    always_comb
    begin
        seq = '0;
        len = LEN_HEX;
        if ((b >= CH_TAB && b <= CH_CR) || b == CH_BACKSLASH)
        begin
            len    = LEN_CTL;
            seq[0] = CH_BACKSLASH;
            seq[1] = (b == CH_BACKSLASH) ? CH_BACKSLASH : ctl_letter(3'(b - CH_TAB));
        end
        else if (b >= CH_SPACE && b <= CH_TILDE)
        begin
            len    = LEN_PLAIN;
            seq[0] = b;
        end
        else
        begin
            len    = LEN_HEX;
            seq[0] = CH_BACKSLASH;
            seq[1] = CH_X;
            seq[2] = hex_digit(b[7:4]);
            seq[3] = hex_digit(b[3:0]);
        end
    end

    // space and size bookkeeping, restarted at the first byte of a string
    always_comb
    begin
        space_eff = active_reg ? space_reg : buffer_size_reg;
        need_base = active_reg ? need_reg : 20'd1;
        need_sum  = {1'b0, need_base} + {18'd0, len};
        need_new  = (need_sum > {1'b0, NEED_MAX}) ? NEED_MAX : need_sum[19:0];
        fits      = space_eff > {13'd0, len};

        new_burst.chars = seq;
        new_burst.nchar = fits ? len : 3'd0;
        new_burst.term  = last;
        new_burst.need  = need_new;
        load_a          = fits || last;
    end

    // handshake between staging and output registers
    assign b_total  = b_burst_reg.nchar + {2'd0, b_burst_reg.term};
    assign b_final  = (b_idx_reg == b_total - 3'd1);
    assign out_fire = text_chars.valid && text_chars.ready;
    assign b_free   = !b_valid_reg || (out_fire && b_final);
    assign a_move   = a_valid_reg && b_free;

    assign raw_bytes.ready = !a_valid_reg || a_move;
    assign in_fire         = raw_bytes.valid && raw_bytes.ready;

    // next state of string tracking and of both registers
    always_comb
    begin
        active_next  = active_reg;
        space_next   = space_reg;
        need_next    = need_reg;
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        b_idx_next   = b_idx_reg;

        if (in_fire)
        begin
            if (last)
            begin
                active_next = 1'b0;
                space_next  = '0;
                need_next   = 20'd1;
            end
            else
            begin
                active_next = 1'b1;
                space_next  = fits ? (space_eff - {13'd0, len}) : space_eff;
                need_next   = need_new;
            end
        end

        if (in_fire && load_a)
            a_valid_next = 1'b1;
        else if (a_move)
            a_valid_next = 1'b0;

        if (b_free)
        begin
            b_valid_next = a_valid_reg;
            b_idx_next   = '0;
        end
        else if (out_fire)
            b_idx_next = b_idx_reg + 3'd1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            space_reg   <= '0;
            need_reg    <= 20'd1;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_idx_reg   <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            space_reg   <= space_next;
            need_reg    <= need_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            b_idx_reg   <= b_idx_next;
        end
    end

    // burst payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire && load_a)
            a_burst_reg <= new_burst;
        if (a_move)
            b_burst_reg <= a_burst_reg;
    end

    // output character selection
    always_comb
    begin
        is_char                          = b_idx_reg < b_burst_reg.nchar;
        text_chars.valid                 = b_valid_reg;
        text_chars.data.out_char         = is_char ? b_burst_reg.chars[b_idx_reg[1:0]] : CH_NUL;
        text_chars.data.is_terminator    = !is_char;
        text_chars.data.needed_total     = is_char ? 20'd0 : b_burst_reg.need;
        text_chars.data.run_last         = b_final;
    end

endmodule

### design/bee_checker.sv
// port-level checks for the byte escape encoder, bound to the top level
module bee_checker
    import bee_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       text_valid,
    input logic       text_ready,
    input text_item_t text_data
);

    // a stalled character request holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid && $stable(text_data))
        else $error("output request changed while stalled");

    // character results carry a nonzero char and no size
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_data.is_terminator |->
            text_data.out_char != 8'h00 && text_data.needed_total == 20'd0)
        else $error("character result with bad char or size");

    // terminator is zero, closes the run and reports a size of at least two
    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_data.is_terminator |->
            text_data.out_char == 8'h00 && text_data.run_last
            && text_data.needed_total > 20'd1)
        else $error("malformed terminator result");

    // nothing comes out in the first cycle after reset
    a_reset: assert property (@(posedge clk)
        rst_n && $past(!rst_n) |-> !text_valid)
        else $error("output valid straight after reset");

endmodule

bind byte_escape_encoder bee_checker u_bee_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text_chars.valid),
    .text_ready (text_chars.ready),
    .text_data  (text_chars.data)
);
